// File: sv/b64_pkg.sv
// Shared types, constants and alphabet functions for the Base64 codec.
package b64_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  typedef struct packed {
    logic [3:0][7:0] chars;
    logic            multi;
    logic            has_data;
    logic            msg_end;
  } job_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  // Bit 6 is set when the character belongs to the alphabet.
  function automatic logic [6:0] b64_sextet(input logic [7:0] ch);
    logic [6:0] r;
    r = 7'd0;
    if (ch inside {[8'h41:8'h5A]}) begin
      r = {1'b1, 6'(ch - 8'h41)};
    end else if (ch inside {[8'h61:8'h7A]}) begin
      r = {1'b1, 6'(ch - 8'h61 + 8'd26)};
    end else if (ch inside {[8'h30:8'h39]}) begin
      r = {1'b1, 6'(ch - 8'h30 + 8'd52)};
    end else if (ch == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (ch == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

// File: sv/b64_front.sv
// Front end: accepts items, keeps the codec state and builds output jobs.
module b64_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic          cfg_data,
  input  logic          req_valid,
  output logic          req_stall,
  input  logic [7:0]    in_byte,
  input  logic          msg_last,
  output b64_pkg::job_t job,
  output logic          job_push,
  input  logic          job_full
);
  import b64_pkg::*;

  logic            direction;
  logic [1:0][7:0] held_bytes;
  logic [1:0][7:0] held_bytes_next;
  logic [1:0]      held_count;
  logic [1:0]      held_count_next;
  logic [13:0]     bit_accum;
  logic [13:0]     bit_accum_next;
  logic [3:0]      bit_count;
  logic [3:0]      bit_count_next;
  logic            pad_seen;
  logic            pad_seen_next;

  logic            accept;
  logic            make_job;
  logic [23:0]     group;
  logic [6:0]      sx;
  logic [13:0]     acc_shift;
  logic [3:0]      cnt_add;
  logic [13:0]     shifted;

  assign req_stall = job_full;
  assign accept    = req_valid && !job_full;
  assign job_push  = accept && make_job;

  always_comb begin
    held_bytes_next = held_bytes;
    held_count_next = held_count;
    bit_accum_next  = bit_accum;
    bit_count_next  = bit_count;
    pad_seen_next   = pad_seen;
    make_job        = 1'b0;
    job             = '0;
    job.msg_end     = msg_last;
    group           = 24'd0;
    sx              = b64_sextet(in_byte);
    acc_shift       = {bit_accum[7:0], sx[5:0]};
    cnt_add         = bit_count + 4'd6;
    shifted         = acc_shift >> (cnt_add - 4'd8);
    if (direction == DIR_ENCODE) begin
      if (held_count < 2'd2 && !msg_last) begin
        held_bytes_next[held_count[0]] = in_byte;
        held_count_next = held_count + 2'd1;
      end else begin
        case (held_count)
          2'd0:    group = {in_byte, 16'd0};
          2'd1:    group = {held_bytes[0], in_byte, 8'd0};
          default: group = {held_bytes[0], held_bytes[1], in_byte};
        endcase
        make_job        = 1'b1;
        job.multi       = 1'b1;
        job.has_data    = 1'b1;
        job.chars[0]    = b64_char(group[23:18]);
        job.chars[1]    = b64_char(group[17:12]);
        job.chars[2]    = (held_count != 2'd0) ? b64_char(group[11:6]) : PAD_CHAR;
        job.chars[3]    = (held_count == 2'd2) ? b64_char(group[5:0]) : PAD_CHAR;
        held_bytes_next = '0;
        held_count_next = 2'd0;
      end
    end else begin
      if (!pad_seen) begin
        if (in_byte == PAD_CHAR) begin
          pad_seen_next = 1'b1;
        end else if (sx[6]) begin
          bit_accum_next = acc_shift;
          bit_count_next = cnt_add;
          if (cnt_add >= 4'd8) begin
            bit_count_next = cnt_add - 4'd8;
            make_job       = 1'b1;
            job.has_data   = 1'b1;
            job.chars[0]   = shifted[7:0];
          end
        end
      end
      if (msg_last) begin
        make_job = 1'b1;
      end
    end
    if (msg_last) begin
      held_bytes_next = '0;
      held_count_next = 2'd0;
      bit_accum_next  = 14'd0;
      bit_count_next  = 4'd0;
      pad_seen_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= DIR_ENCODE;
      held_bytes <= '0;
      held_count <= 2'd0;
      bit_accum  <= 14'd0;
      bit_count  <= 4'd0;
      pad_seen   <= 1'b0;
    end else if (cfg_write) begin
      direction  <= cfg_data;
      held_bytes <= '0;
      held_count <= 2'd0;
      bit_accum  <= 14'd0;
      bit_count  <= 4'd0;
      pad_seen   <= 1'b0;
    end else if (accept) begin
      held_bytes <= held_bytes_next;
      held_count <= held_count_next;
      bit_accum  <= bit_accum_next;
      bit_count  <= bit_count_next;
      pad_seen   <= pad_seen_next;
    end
  end

endmodule

// File: sv/b64_queue.sv
// Short job queue between the front end and the output sequencer.
module b64_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  b64_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output b64_pkg::job_t pop_data,
  output logic          empty
);
  import b64_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("Job queue written while full.");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("Job queue read while empty.");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("Job queue count out of range.");
`endif

endmodule

// File: sv/b64_back.sv
// Output sequencer: expands each job into one or four result items.
module b64_back (
  input  logic          clk,
  input  logic          rst,
  input  b64_pkg::job_t job_data,
  input  logic          job_empty,
  output logic          job_pop,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output logic [7:0]    out_byte,
  output logic          has_data,
  output logic          run_last,
  output logic          msg_end
);
  import b64_pkg::*;

  job_t       cur;
  logic       busy;
  logic [1:0] idx;
  logic       fire;
  logic       last_res;

  assign fire     = busy && !rsp_stall;
  assign last_res = !cur.multi || (idx == 2'd3);
  assign job_pop  = !job_empty && (!busy || (fire && last_res));

  assign rsp_valid = busy;
  assign out_byte  = cur.chars[idx];
  assign has_data  = cur.has_data;
  assign run_last  = last_res;
  assign msg_end   = cur.msg_end;

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (job_pop) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (fire) begin
      if (last_res) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !has_data |-> run_last && msg_end)
    else $error("Empty result item is not a message end.");
  a_idx_multi: assert property (@(posedge clk) disable iff (rst)
    busy && idx != 2'd0 |-> cur.multi)
    else $error("Result index advanced on a single-result job.");
  a_group_continues: assert property (@(posedge clk) disable iff (rst)
    fire && !last_res |=> rsp_valid && idx != 2'd0)
    else $error("Character group broken off before its last item.");
`endif

endmodule

// File: sv/base64_codec_unit.sv
// Top level of the streaming Base64 codec.
//
//   port group   role     items
//   req_*        in       one data byte or character per item, msg_last marks end
//   rsp_*        out      one character or byte per item, with end flags
//   cfg_*        in       direction register write, 0 encode, 1 decode
//
// Each input item is taken in the same cycle that it is offered, when the job queue has room.
// Results leave at one per cycle while rsp_stall is low: four per encoded group,
// at most one per decoded item.
// Reset clears the direction to encode, the codec state and the job queue.
// Either side may stall; the job queue lets the front end run ahead by QUEUE_DEPTH jobs.
module base64_codec_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [7:0] in_byte,
  input  logic       msg_last,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [7:0] out_byte,
  output logic       has_data,
  output logic       run_last,
  output logic       msg_end
);
  import b64_pkg::*;

  job_t push_job;
  job_t pop_job;
  logic push;
  logic full;
  logic pop;
  logic empty;

  b64_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .in_byte   (in_byte),
    .msg_last  (msg_last),
    .job       (push_job),
    .job_push  (push),
    .job_full  (full)
  );

  b64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_job),
    .empty     (empty)
  );

  b64_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_data  (pop_job),
    .job_empty (empty),
    .job_pop   (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .out_byte  (out_byte),
    .has_data  (has_data),
    .run_last  (run_last),
    .msg_end   (msg_end)
  );

endmodule

// File: dv/base64_codec_unit_test.sv
// Self-checking testbench for the streaming Base64 codec in encode and decode modes.
module base64_codec_unit_test;
  import b64_pkg::*;

  typedef struct packed {
    logic [7:0] symbol;
    logic       has_data;
    logic       run_last;
    logic       msg_end;
  } codec_result_t;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic       cfg_data;
  logic       req_valid;
  logic       req_stall;
  logic [7:0] in_byte;
  logic       msg_last;
  logic       rsp_valid;
  logic       rsp_stall;
  logic [7:0] out_byte;
  logic       has_data;
  logic       run_last;
  logic       msg_end;

  string         b64_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  codec_result_t pending_results[$];
  logic [7:0]    msg_buf[$];

  logic        mode_dir;
  logic [7:0]  enc_held[2];
  int          enc_count;
  logic [13:0] dec_bits;
  int          dec_nbits;
  bit          dec_padded;

  int mismatches;
  int items_seen;
  int results_seen;
  bit tx_idle_en;
  bit rx_idle_en;
  int rx_hold_req;
  int rx_hold_left;
  int rx_burst;

  base64_codec_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .in_byte   (in_byte),
    .msg_last  (msg_last),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .out_byte  (out_byte),
    .has_data  (has_data),
    .run_last  (run_last),
    .msg_end   (msg_end)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 300000);
    $display("simulation failed");
    $finish;
  end

  function automatic int sextet_value(input logic [7:0] ch);
    int v;
    v = -1;
    if (ch >= "A" && ch <= "Z") begin
      v = ch - "A";
    end else if (ch >= "a" && ch <= "z") begin
      v = ch - "a" + 26;
    end else if (ch >= "0" && ch <= "9") begin
      v = ch - "0" + 52;
    end else if (ch == "+") begin
      v = 62;
    end else if (ch == "/") begin
      v = 63;
    end
    return v;
  endfunction

  task automatic want_add(input codec_result_t r);
    pending_results = {pending_results, r};
  endtask

  task automatic buf_add(input logic [7:0] b);
    msg_buf = {msg_buf, b};
  endtask

  task automatic codec_clear();
    enc_held[0] = 8'h00;
    enc_held[1] = 8'h00;
    enc_count = 0;
    dec_bits = 14'h0;
    dec_nbits = 0;
    dec_padded = 1'b0;
  endtask

  task automatic predict_codec(input logic [7:0] b, input logic last);
    logic [23:0]   grp;
    logic [7:0]    outb;
    int            n;
    int            v;
    bit            made;
    codec_result_t r;
    if (mode_dir == DIR_ENCODE) begin
      if (enc_count < 2 && !last) begin
        enc_held[enc_count] = b;
        enc_count++;
      end else begin
        n = enc_count + 1;
        case (enc_count)
          0: grp = {b, 16'h0000};
          1: grp = {enc_held[0], b, 8'h00};
          default: grp = {enc_held[0], enc_held[1], b};
        endcase
        for (int k = 0; k < 4; k++) begin
          r.symbol = (n < k) ? PAD_CHAR : b64_alpha[grp[23 - 6 * k -: 6]];
          r.has_data = 1'b1;
          r.run_last = (k == 3);
          r.msg_end = last;
          want_add(r);
        end
        enc_count = 0;
        enc_held[0] = 8'h00;
        enc_held[1] = 8'h00;
      end
    end else begin
      made = 1'b0;
      outb = 8'h00;
      if (!dec_padded) begin
        if (b == PAD_CHAR) begin
          dec_padded = 1'b1;
        end else begin
          v = sextet_value(b);
          if (v >= 0) begin
            dec_bits = {dec_bits[7:0], 6'(v)};
            dec_nbits += 6;
            if (dec_nbits >= 8) begin
              outb = 8'(dec_bits >> (dec_nbits - 8));
              dec_nbits -= 8;
              made = 1'b1;
            end
          end
        end
      end
      if (made) begin
        r = '{outb, 1'b1, 1'b1, last};
        want_add(r);
      end else if (last) begin
        r = '{8'h00, 1'b0, 1'b1, 1'b1};
        want_add(r);
      end
    end
    if (last) begin
      codec_clear();
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s is %0h, expected %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  always @(negedge clk) begin : monitor
    codec_result_t want;
    if (rst) begin
      mode_dir = DIR_ENCODE;
      codec_clear();
    end else begin
      if (cfg_write) begin
        mode_dir = cfg_data;
        codec_clear();
      end
      if (req_valid && !req_stall) begin
        predict_codec(in_byte, msg_last);
        items_seen++;
      end
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected item, out_byte", out_byte, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_byte !== want.symbol) report_mismatch("out_byte", out_byte, want.symbol);
          if (has_data !== want.has_data) report_mismatch("has_data", has_data, want.has_data);
          if (run_last !== want.run_last) report_mismatch("run_last", run_last, want.run_last);
          if (msg_end !== want.msg_end) report_mismatch("msg_end", msg_end, want.msg_end);
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    logic stall_next;
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_hold_left > 0) begin
      stall_next = 1'b1;
      rx_hold_left--;
    end else if (rx_burst > 0) begin
      stall_next = 1'b1;
      rx_burst--;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      stall_next = 1'b1;
      rx_burst = $urandom_range(0, 11);
    end else begin
      stall_next = 1'b0;
    end
    rsp_stall <= stall_next;
  end

  task automatic send_item(input logic [7:0] b, input logic last);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_valid <= 1'b1;
    in_byte <= b;
    msg_last <= last;
    do begin
      @(negedge clk);
    end while (req_stall);
    @(posedge clk);
  endtask

  task automatic send_buf(input bit close);
    for (int i = 0; i < msg_buf.size(); i++) begin
      send_item(msg_buf[i], close && (i == msg_buf.size() - 1));
    end
    msg_buf.delete();
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_direction(input logic dir);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= dir;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic make_b64_text();
    int groups;
    int pads;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 8)) buf_add(8'($urandom_range(0, 255)));
    end else begin
      groups = $urandom_range(1, 3);
      for (int g = 0; g < groups * 4; g++) begin
        buf_add(b64_alpha[$urandom_range(0, 63)]);
        if ($urandom_range(0, 19) == 0) buf_add(8'($urandom_range(0, 255)));
      end
      pads = $urandom_range(0, 2);
      for (int j = 0; j < pads; j++) msg_buf[msg_buf.size() - 1 - j] = PAD_CHAR;
      if ($urandom_range(0, 3) == 0) buf_add(b64_alpha[$urandom_range(0, 63)]);
    end
  endtask

  task automatic test_encode_directed();
    set_direction(DIR_ENCODE);
    msg_buf = '{"f"};
    send_buf(1'b1);
    msg_buf = '{"f", "o"};
    send_buf(1'b1);
    msg_buf = '{"f", "o", "o"};
    send_buf(1'b1);
    msg_buf = '{8'h00, 8'hFF, 8'h00, 8'hFF};
    send_buf(1'b1);
    msg_buf = '{8'hFF, 8'hFF};
    send_buf(1'b1);
    msg_buf = '{8'h41, 8'h42};
    send_buf(1'b0);
  endtask

  task automatic test_decode_directed();
    set_direction(DIR_DECODE);
    msg_buf = '{"Z", "g", "=", "=", "X"};
    send_buf(1'b1);
    msg_buf = '{"*", "+", "/"};
    send_buf(1'b1);
    msg_buf = '{8'hFF};
    send_buf(1'b1);
    msg_buf = '{"A", "B"};
    send_buf(1'b0);
    set_direction(DIR_ENCODE);
  endtask

  task automatic test_encode_random();
    int sent;
    set_direction(DIR_ENCODE);
    sent = 0;
    while (sent < 35) begin
      repeat ($urandom_range(1, 9)) buf_add(8'($urandom_range(0, 255)));
      sent += msg_buf.size();
      send_buf(1'b1);
    end
  endtask

  task automatic test_decode_random();
    int sent;
    set_direction(DIR_DECODE);
    sent = 0;
    while (sent < 35) begin
      make_b64_text();
      sent += msg_buf.size();
      send_buf(1'b1);
    end
  endtask

  task automatic test_backpressure();
    set_direction(DIR_ENCODE);
    rx_hold_req = 80;
    repeat (3) begin
      repeat (8) buf_add(8'($urandom_range(0, 255)));
      send_buf(1'b1);
    end
    drain();
  endtask

  task automatic test_no_idle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    set_direction(DIR_DECODE);
    repeat (2) begin
      make_b64_text();
      send_buf(1'b1);
    end
    set_direction(DIR_ENCODE);
    repeat (2) begin
      repeat ($urandom_range(4, 7)) buf_add(8'($urandom_range(0, 255)));
      send_buf(1'b1);
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= 1'b0;
    req_valid <= 1'b0;
    in_byte <= 8'h00;
    msg_last <= 1'b0;
    rsp_stall <= 1'b0;
    mismatches = 0;
    items_seen = 0;
    results_seen = 0;
    rx_hold_req = 0;
    rx_hold_left = 0;
    rx_burst = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_encode_directed();
    test_decode_directed();
    test_encode_random();
    test_decode_random();
    test_backpressure();
    test_no_idle();
    drain();
    $display("Sent %0d items and checked %0d results across encode and decode messages,",
             items_seen, results_seen);
    $display("including padding, skipped characters, empty end markers and a long output hold.");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
